@@ hw/rtl/cau_pkg.sv @@
// Shared widths, command and status codes, and the saturation helper
// for the complex arithmetic unit. No dependencies.
`default_nettype none

package cau_pkg;

    localparam int DATA_W   = 32;                    // Q8.24 word
    localparam int FRAC_W   = 24;
    localparam int CMD_W    = 4;
    localparam int STAT_W   = 2;
    localparam int PROD_W   = 2 * DATA_W;            // one full product
    localparam int SUM_W    = PROD_W + 1;            // sum of two products
    localparam int WIDE_W   = PROD_W + 2;            // headroom for rounding and saturation
    localparam int NUM_W    = PROD_W + FRAC_W;       // dividend after the fraction shift
    localparam int SQ_STEPS = DATA_W;                // one root bit per stage
    localparam int DV_STEPS = DATA_W;                // one quotient bit per stage
    localparam int SQ_REM_W = DATA_W + 2;

    localparam logic [CMD_W-1:0] CMD_ADD  = 4'd0;
    localparam logic [CMD_W-1:0] CMD_SUB  = 4'd1;
    localparam logic [CMD_W-1:0] CMD_MUL  = 4'd2;
    localparam logic [CMD_W-1:0] CMD_DIV  = 4'd3;
    localparam logic [CMD_W-1:0] CMD_MAG  = 4'd4;
    localparam logic [CMD_W-1:0] CMD_CONJ = 4'd5;
    localparam logic [CMD_W-1:0] CMD_NEG  = 4'd6;
    localparam logic [CMD_W-1:0] CMD_EQ   = 4'd7;
    localparam logic [CMD_W-1:0] CMD_NORM = 4'd8;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_DIV0  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NORM0 = 2'd2;
    localparam logic [STAT_W-1:0] STAT_SAT   = 2'd3;

    typedef logic signed [DATA_W-1:0] t_data;

    typedef struct packed {
        t_data val;
        logic  flag;
    } t_sat;

    localparam t_data DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam t_data DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [WIDE_W-1:0] WIDE_MAX = WIDE_W'(DATA_MAX);
    localparam logic signed [WIDE_W-1:0] WIDE_MIN = WIDE_W'(DATA_MIN);

    // Clamp a wide signed value into the data range and flag a clamp.
    function automatic t_sat sat_wide(input logic signed [WIDE_W-1:0] v);
        t_sat r;
        if (v > WIDE_MAX) begin
            r.val  = DATA_MAX;
            r.flag = 1'b1;
        end else if (v < WIDE_MIN) begin
            r.val  = DATA_MIN;
            r.flag = 1'b1;
        end else begin
            r.val  = v[DATA_W-1:0];
            r.flag = 1'b0;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/cau_if.sv @@
// Valid/ready channel interfaces for the complex arithmetic unit:
// the command channel and the result channel. Depends on cau_pkg.
`default_nettype none

interface cau_in_if;
    import cau_pkg::*;

    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   cmd;
    t_data              a_re;
    t_data              a_im;
    t_data              b_re;
    t_data              b_im;

    modport source (output valid, cmd, a_re, a_im, b_re, b_im, input ready);
    modport sink   (input valid, cmd, a_re, a_im, b_re, b_im, output ready);
endinterface

interface cau_out_if;
    import cau_pkg::*;

    logic               valid;
    logic               ready;
    t_data              res_re;
    t_data              res_im;
    logic               is_equal;
    logic [STAT_W-1:0]  status;

    modport source (output valid, res_re, res_im, is_equal, status, input ready);
    modport sink   (input valid, res_re, res_im, is_equal, status, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/complex_arithmetic_unit.sv @@
// Complex arithmetic unit: one command per cycle while not stalled; a command passes
// from the input transfer to the offered result through the input register, product stage,
// sum stage, setup stage, 32 square-root stages, divider setup stage, 32 restoring-division
// stages and the output stage, 70 registers in all, the first loaded by the transfer.
// Throughput is one transfer per cycle; a held result stalls the whole pipe in place.
// Synchronous active-low reset clears the valid bits only. Depends on cau_pkg, cau_if.
`default_nettype none

module complex_arithmetic_unit (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    cau_in_if.sink    i_in,
    cau_out_if.source o_out
);
    import cau_pkg::*;

    typedef struct packed {
        logic              valid;
        logic [CMD_W-1:0]  cmd;
        t_data             ar;
        t_data             ai;
        t_data             br;
        t_data             bi;
    } t_stage_a;

    typedef struct packed {
        logic                     valid;
        logic [CMD_W-1:0]         cmd;
        t_data                    ar;
        t_data                    ai;
        logic signed [PROD_W-1:0] p_rr;
        logic signed [PROD_W-1:0] p_ii;
        logic signed [PROD_W-1:0] p_ri;
        logic signed [PROD_W-1:0] p_ir;
        logic signed [PROD_W-1:0] p_x2;
        logic signed [PROD_W-1:0] p_y2;
        t_data                    s_re;
        t_data                    s_im;
        logic                     s_flag;
        logic                     eq;
    } t_stage_b;

    typedef struct packed {
        logic                    valid;
        logic [CMD_W-1:0]        cmd;
        logic [DATA_W-1:0]       ar_abs;
        logic                    ar_neg;
        logic [DATA_W-1:0]       ai_abs;
        logic                    ai_neg;
        t_data                   s_re;
        t_data                   s_im;
        logic                    s_flag;
        logic                    eq;
        logic signed [SUM_W-1:0] w_re;
        logic signed [SUM_W-1:0] w_im;
        logic [PROD_W-1:0]       den;
    } t_stage_c;

    typedef struct packed {
        logic                  valid;
        logic [CMD_W-1:0]      cmd;
        t_data                 s_re;
        t_data                 s_im;
        logic                  s_flag;
        logic                  eq;
        logic                  zero;
        logic [DATA_W-1:0]     ar_abs;
        logic                  ar_neg;
        logic [DATA_W-1:0]     ai_abs;
        logic                  ai_neg;
        logic [NUM_W-1:0]      n_re_abs;
        logic                  n_re_neg;
        logic [NUM_W-1:0]      n_im_abs;
        logic                  n_im_neg;
        logic [PROD_W-1:0]     den;
        logic [PROD_W-1:0]     sq_val;
        logic [SQ_REM_W-1:0]   sq_rem;
        logic [DATA_W-1:0]     sq_root;
        logic                  ovf_re;
        logic                  ovf_im;
        logic [PROD_W-1:0]     dv_rem_re;
        logic [PROD_W-1:0]     dv_rem_im;
        logic [DATA_W-1:0]     dv_low_re;
        logic [DATA_W-1:0]     dv_low_im;
        logic [DATA_W-1:0]     q_re;
        logic [DATA_W-1:0]     q_im;
    } t_work;

    typedef struct packed {
        logic              valid;
        t_data             re;
        t_data             im;
        logic              eq;
        logic [STAT_W-1:0] status;
    } t_result;

    localparam logic signed [WIDE_W-1:0] TRUNC_ADJ = (WIDE_W'(1) <<< FRAC_W) - WIDE_W'(1);

    // One step of the digit-by-digit floor square root: two radicand bits in,
    // one root bit out.
    function automatic t_work sqrt_step(input t_work w);
        t_work               r;
        logic [SQ_REM_W+1:0] cur;
        logic [SQ_REM_W+1:0] trial;
        r     = w;
        cur   = {w.sq_rem, w.sq_val[PROD_W-1 -: 2]};
        trial = {2'b00, w.sq_root, 2'b01};
        r.sq_val = {w.sq_val[PROD_W-3:0], 2'b00};
        if (cur >= trial) begin
            r.sq_rem  = SQ_REM_W'(cur - trial);
            r.sq_root = {w.sq_root[DATA_W-2:0], 1'b1};
        end else begin
            r.sq_rem  = cur[SQ_REM_W-1:0];
            r.sq_root = {w.sq_root[DATA_W-2:0], 1'b0};
        end
        return r;
    endfunction

    // One restoring-division step on both lanes. The partial remainder stays
    // below the divisor, so the shifted value fits one bit more than the divisor.
    function automatic t_work div_step(input t_work w);
        t_work           r;
        logic [PROD_W:0] cur_re;
        logic [PROD_W:0] cur_im;
        logic [PROD_W:0] dz;
        r      = w;
        dz     = {1'b0, w.den};
        cur_re = {w.dv_rem_re, w.dv_low_re[DATA_W-1]};
        cur_im = {w.dv_rem_im, w.dv_low_im[DATA_W-1]};
        r.dv_low_re = {w.dv_low_re[DATA_W-2:0], 1'b0};
        r.dv_low_im = {w.dv_low_im[DATA_W-2:0], 1'b0};
        if (cur_re >= dz) begin
            r.dv_rem_re = PROD_W'(cur_re - dz);
            r.q_re      = {w.q_re[DATA_W-2:0], 1'b1};
        end else begin
            r.dv_rem_re = cur_re[PROD_W-1:0];
            r.q_re      = {w.q_re[DATA_W-2:0], 1'b0};
        end
        if (cur_im >= dz) begin
            r.dv_rem_im = PROD_W'(cur_im - dz);
            r.q_im      = {w.q_im[DATA_W-2:0], 1'b1};
        end else begin
            r.dv_rem_im = cur_im[PROD_W-1:0];
            r.q_im      = {w.q_im[DATA_W-2:0], 1'b0};
        end
        return r;
    endfunction

    // Apply the sign to an unsigned quotient and clamp it.
    function automatic t_sat quot_out(input logic [DATA_W-1:0] q, input logic neg,
                                      input logic ovf);
        t_sat r;
        r.flag = 1'b0;
        if (ovf) begin
            r.flag = 1'b1;
            r.val  = neg ? DATA_MIN : DATA_MAX;
        end else if (neg) begin
            if (q > DATA_MIN) begin
                r.flag = 1'b1;
                r.val  = DATA_MIN;
            end else begin
                r.val = t_data'(~q + DATA_W'(1));
            end
        end else if (q[DATA_W-1]) begin
            r.flag = 1'b1;
            r.val  = DATA_MAX;
        end else begin
            r.val = t_data'(q);
        end
        return r;
    endfunction

    logic     en;
    t_stage_a r_a;
    t_stage_b r_b, n_b;
    t_stage_c r_c, n_c;
    t_work    n_d;
    t_work    n_e;
    t_work    r_sq [0:SQ_STEPS];
    t_work    n_sq [0:SQ_STEPS];
    t_work    r_dv [0:DV_STEPS];
    t_work    n_dv [0:DV_STEPS];
    t_result  r_f, n_f;

    // The pipe moves whenever the output register is empty or being drained.
    assign en         = !r_f.valid || o_out.ready;
    assign i_in.ready = en;

    // Stage B: the six products and the commands that need no multiplier.
    always_comb begin
        t_data  x;
        t_data  y;
        t_sat   sr;
        t_sat   si;
        x = (r_a.cmd == CMD_DIV) ? r_a.br : r_a.ar;
        y = (r_a.cmd == CMD_DIV) ? r_a.bi : r_a.ai;
        sr = '{val: '0, flag: 1'b0};
        si = '{val: '0, flag: 1'b0};
        n_b.valid = r_a.valid;
        n_b.cmd   = r_a.cmd;
        n_b.ar    = r_a.ar;
        n_b.ai    = r_a.ai;
        n_b.p_rr  = r_a.ar * r_a.br;
        n_b.p_ii  = r_a.ai * r_a.bi;
        n_b.p_ri  = r_a.ar * r_a.bi;
        n_b.p_ir  = r_a.ai * r_a.br;
        n_b.p_x2  = x * x;
        n_b.p_y2  = y * y;
        n_b.eq    = 1'b0;
        case (r_a.cmd)
            CMD_ADD: begin
                sr = sat_wide(WIDE_W'(r_a.ar) + WIDE_W'(r_a.br));
                si = sat_wide(WIDE_W'(r_a.ai) + WIDE_W'(r_a.bi));
            end
            CMD_SUB: begin
                sr = sat_wide(WIDE_W'(r_a.ar) - WIDE_W'(r_a.br));
                si = sat_wide(WIDE_W'(r_a.ai) - WIDE_W'(r_a.bi));
            end
            CMD_CONJ: begin
                sr = sat_wide(WIDE_W'(r_a.ar));
                si = sat_wide(-WIDE_W'(r_a.ai));
            end
            CMD_NEG: begin
                sr = sat_wide(-WIDE_W'(r_a.ar));
                si = sat_wide(-WIDE_W'(r_a.ai));
            end
            CMD_EQ: begin
                n_b.eq = (r_a.ar == r_a.br) && (r_a.ai == r_a.bi);
            end
            default: begin
            end
        endcase
        n_b.s_re   = sr.val;
        n_b.s_im   = si.val;
        n_b.s_flag = sr.flag | si.flag;
    end

    // Stage C: sums of products and operand magnitudes.
    always_comb begin
        n_c.valid  = r_b.valid;
        n_c.cmd    = r_b.cmd;
        n_c.s_re   = r_b.s_re;
        n_c.s_im   = r_b.s_im;
        n_c.s_flag = r_b.s_flag;
        n_c.eq     = r_b.eq;
        n_c.ar_neg = r_b.ar[DATA_W-1];
        n_c.ai_neg = r_b.ai[DATA_W-1];
        n_c.ar_abs = r_b.ar[DATA_W-1] ? DATA_W'(~r_b.ar + DATA_W'(1)) : DATA_W'(r_b.ar);
        n_c.ai_abs = r_b.ai[DATA_W-1] ? DATA_W'(~r_b.ai + DATA_W'(1)) : DATA_W'(r_b.ai);
        if (r_b.cmd == CMD_MUL) begin
            n_c.w_re = SUM_W'(r_b.p_rr) - SUM_W'(r_b.p_ii);
            n_c.w_im = SUM_W'(r_b.p_ri) + SUM_W'(r_b.p_ir);
        end else begin
            n_c.w_re = SUM_W'(r_b.p_rr) + SUM_W'(r_b.p_ii);
            n_c.w_im = SUM_W'(r_b.p_ir) - SUM_W'(r_b.p_ri);
        end
        // Both squares are nonnegative and at most 2^62, so the sum fits unsigned.
        n_c.den = PROD_W'($unsigned(r_b.p_x2)) + PROD_W'($unsigned(r_b.p_y2));
    end

    // Stage D: finish multiply, set up dividends and the square-root radicand.
    always_comb begin
        logic signed [WIDE_W-1:0] v_re;
        logic signed [WIDE_W-1:0] v_im;
        logic signed [SUM_W-1:0]  a_re;
        logic signed [SUM_W-1:0]  a_im;
        t_sat                     mr;
        t_sat                     mi;
        v_re = WIDE_W'(r_c.w_re);
        v_im = WIDE_W'(r_c.w_im);
        // Biasing negative values before the arithmetic shift truncates toward zero.
        if (v_re < 0) v_re = v_re + TRUNC_ADJ;
        if (v_im < 0) v_im = v_im + TRUNC_ADJ;
        mr   = sat_wide(v_re >>> FRAC_W);
        mi   = sat_wide(v_im >>> FRAC_W);
        a_re = r_c.w_re[SUM_W-1] ? -r_c.w_re : r_c.w_re;
        a_im = r_c.w_im[SUM_W-1] ? -r_c.w_im : r_c.w_im;

        n_d          = '0;
        n_d.valid    = r_c.valid;
        n_d.cmd      = r_c.cmd;
        n_d.eq       = r_c.eq;
        n_d.ar_abs   = r_c.ar_abs;
        n_d.ar_neg   = r_c.ar_neg;
        n_d.ai_abs   = r_c.ai_abs;
        n_d.ai_neg   = r_c.ai_neg;
        n_d.zero     = (r_c.den == '0);
        n_d.den      = r_c.den;
        n_d.sq_val   = r_c.den;
        n_d.n_re_neg = r_c.w_re[SUM_W-1];
        n_d.n_im_neg = r_c.w_im[SUM_W-1];
        n_d.n_re_abs = {a_re[PROD_W-1:0], FRAC_W'(0)};
        n_d.n_im_abs = {a_im[PROD_W-1:0], FRAC_W'(0)};
        if (r_c.cmd == CMD_MUL) begin
            n_d.s_re   = mr.val;
            n_d.s_im   = mi.val;
            n_d.s_flag = mr.flag | mi.flag;
        end else begin
            n_d.s_re   = r_c.s_re;
            n_d.s_im   = r_c.s_im;
            n_d.s_flag = r_c.s_flag;
        end
    end

    always_comb begin
        n_sq[0] = n_d;
        for (int k = 0; k < SQ_STEPS; k++) begin
            n_sq[k+1] = sqrt_step(r_sq[k]);
        end
    end

    // Stage E: pick the divider operands and check that the quotient fits.
    always_comb begin
        t_work            w;
        logic [NUM_W-1:0] num_re;
        logic [NUM_W-1:0] num_im;
        logic [PROD_W-1:0] hi_re;
        logic [PROD_W-1:0] hi_im;
        w = r_sq[SQ_STEPS];
        if (w.cmd == CMD_NORM) begin
            num_re     = NUM_W'({w.ar_abs, FRAC_W'(0)});
            num_im     = NUM_W'({w.ai_abs, FRAC_W'(0)});
            w.n_re_neg = w.ar_neg;
            w.n_im_neg = w.ai_neg;
            w.den      = PROD_W'(w.sq_root);
        end else begin
            num_re = w.n_re_abs;
            num_im = w.n_im_abs;
        end
        hi_re = PROD_W'(num_re[NUM_W-1:DATA_W]);
        hi_im = PROD_W'(num_im[NUM_W-1:DATA_W]);
        w.ovf_re    = (hi_re >= w.den);
        w.ovf_im    = (hi_im >= w.den);
        w.dv_rem_re = hi_re;
        w.dv_rem_im = hi_im;
        w.dv_low_re = num_re[DATA_W-1:0];
        w.dv_low_im = num_im[DATA_W-1:0];
        w.q_re      = '0;
        w.q_im      = '0;
        if (w.cmd == CMD_MAG) begin
            w.s_im = '0;
            if (w.sq_root[DATA_W-1]) begin
                w.s_re   = DATA_MAX;
                w.s_flag = 1'b1;
            end else begin
                w.s_re   = t_data'(w.sq_root);
                w.s_flag = 1'b0;
            end
        end
        n_e = w;
    end

    always_comb begin
        n_dv[0] = n_e;
        for (int k = 0; k < DV_STEPS; k++) begin
            n_dv[k+1] = div_step(r_dv[k]);
        end
    end

    // Output stage: signs, clamps and status.
    always_comb begin
        t_work w;
        t_sat  qr;
        t_sat  qi;
        logic  flag;
        w     = r_dv[DV_STEPS];
        qr    = quot_out(w.q_re, w.n_re_neg, w.ovf_re);
        qi    = quot_out(w.q_im, w.n_im_neg, w.ovf_im);
        n_f.valid  = w.valid;
        n_f.eq     = w.eq;
        n_f.re     = w.s_re;
        n_f.im     = w.s_im;
        flag       = w.s_flag;
        n_f.status = STAT_OK;
        if (w.cmd == CMD_DIV || w.cmd == CMD_NORM) begin
            if (w.zero) begin
                n_f.re     = '0;
                n_f.im     = '0;
                flag       = 1'b0;
                n_f.status = (w.cmd == CMD_DIV) ? STAT_DIV0 : STAT_NORM0;
            end else begin
                n_f.re = qr.val;
                n_f.im = qi.val;
                flag   = qr.flag | qi.flag;
            end
        end
        if (n_f.status == STAT_OK && flag) n_f.status = STAT_SAT;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a.valid <= 1'b0;
            r_b.valid <= 1'b0;
            r_c.valid <= 1'b0;
            for (int k = 0; k <= SQ_STEPS; k++) r_sq[k].valid <= 1'b0;
            for (int k = 0; k <= DV_STEPS; k++) r_dv[k].valid <= 1'b0;
            r_f.valid <= 1'b0;
        end else if (en) begin
            r_a.valid <= i_in.valid;
            r_a.cmd   <= i_in.cmd;
            r_a.ar    <= i_in.a_re;
            r_a.ai    <= i_in.a_im;
            r_a.br    <= i_in.b_re;
            r_a.bi    <= i_in.b_im;
            r_b       <= n_b;
            r_c       <= n_c;
            for (int k = 0; k <= SQ_STEPS; k++) r_sq[k] <= n_sq[k];
            for (int k = 0; k <= DV_STEPS; k++) r_dv[k] <= n_dv[k];
            r_f       <= n_f;
        end
    end

    assign o_out.valid    = r_f.valid;
    assign o_out.res_re   = r_f.re;
    assign o_out.res_im   = r_f.im;
    assign o_out.is_equal = r_f.eq;
    assign o_out.status   = r_f.status;

endmodule

`default_nettype wire
